[rtl/esc_pkg.sv]
`default_nettype none

package esc_pkg;

   // field widths
   localparam int CMD_W    = 3;
   localparam int STAMP_W  = 32;
   localparam int TV_W     = 16;
   localparam int CLK_W    = 30;
   localparam int CPR_W    = 16;
   localparam int GAIN_W   = 16;
   localparam int SLOPE_W  = 16;
   localparam int OFFSET_W = 16;
   localparam int TGT_W    = 12;
   localparam int DUTY_W   = 7;
   localparam int SPEED_W  = 20;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   // fixed point
   localparam int FRAC_W     = 8;
   localparam int SUM_FRAC_W = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TARGET = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ESTOP  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CLOCK_HZ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CPR        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_TARGET = 3'd5;

   // reset values
   localparam logic [CLK_W-1:0]           CLOCK_HZ_RST   = 30'd32768;
   localparam logic [CPR_W-1:0]           CPR_RST        = 16'd4480;
   localparam logic [GAIN_W-1:0]          GAIN_RST       = 16'd640;
   localparam logic [SLOPE_W-1:0]         SLOPE_RST      = 16'd128;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RST     = 16'sd2560;
   localparam logic [TGT_W-1:0]           MAX_TARGET_RST = 12'd500;
   localparam logic [TGT_W-1:0]           TARGET_RST     = 12'd50;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;
   localparam int RPM_PER_RPS = 60;

   localparam int DEF_QUEUE_DEPTH      = 4;
   localparam int DEF_EDGES_PER_SAMPLE = 8;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

[rtl/esc_fifo.sv]
`default_nettype none

module esc_fifo import esc_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int WIDTH = STAMP_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output fifo_status_type       status
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int TSUM_W = FILL_W + 1;

   logic [WIDTH-1:0]  mem [DEPTH];
   logic [PTR_W-1:0]  head_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [WIDTH-1:0]  pop_data_ff;
   logic [TSUM_W-1:0] tail_sum;
   logic [PTR_W-1:0]  tail;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (fill_ff == FILL_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      tail_sum = TSUM_W'(head_ff) + TSUM_W'(fill_ff);
      if (tail_sum >= TSUM_W'(DEPTH)) begin
         tail_sum = tail_sum - TSUM_W'(DEPTH);
      end
      tail = tail_sum[PTR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_pop) begin
            head_ff <= (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail] <= push_data;
      end
      if (do_pop) begin
         pop_data_ff <= mem[head_ff];
      end
   end

   assign pop_data = pop_data_ff;

endmodule

`default_nettype wire

[rtl/esc_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle, quotient saturates to all ones.
module esc_div #(
   parameter int NUM_W = 47,
   parameter int DEN_W = 48,
   parameter int QUO_W = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] q_ff;
   logic             sat_ff;

   logic [DEN_W:0]   rem_shift;
   logic [DEN_W+1:0] trial;
   logic             qbit;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      trial     = {1'b0, rem_shift} - {2'b00, den_ff};
      qbit      = !trial[DEN_W+1];
      rem_in    = qbit ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         q_ff   <= '0;
         sat_ff <= (den == '0);
      end else if (busy_ff) begin
         num_ff <= num_ff << 1;
         rem_ff <= rem_in;
         q_ff   <= {q_ff[QUO_W-2:0], qbit};
         // a one shifted out of the top means quotient overflow
         sat_ff <= sat_ff | q_ff[QUO_W-1];
      end
   end

   assign done = done_ff;
   assign quo  = sat_ff ? '1 : q_ff;

endmodule

`default_nettype wire

[rtl/encoder_speed_controller_top.sv]
`default_nettype none

// Encoder speed controller. Each accepted request produces exactly one response carrying
// duty, enable flag, last measured speed (Q12.8 rpm) and status. Encoder edge, set target,
// emergency stop, re-enable and unknown commands go straight to the response. A control
// tick with an empty queue or one that pops a zero period skips the measurement and only
// recomputes the duty. A control tick that pops a nonzero period first runs the bit-serial
// divider, which resolves one bit of 60*EPS*clock_hz*256 per cycle against
// period*counts_per_rev. One request is in flight at a time. A finished response waits in
// the output register while the next request is taken, and a stalled response side adds its
// stall cycles once that register is occupied. The config port is always ready; write it
// only while idle.
module encoder_speed_controller_top import esc_pkg::*; #(
   parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
   parameter int EDGES_PER_SAMPLE = DEF_EDGES_PER_SAMPLE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [STAMP_W-1:0]    req_stamp,
   input  wire logic [TV_W-1:0]       req_target_value,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [DUTY_W-1:0]     rsp_duty,
   output logic                       rsp_enabled,
   output logic      [SPEED_W-1:0]    rsp_speed_q8,
   output logic      [STATUS_W-1:0]   rsp_status,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NUM_K  = RPM_PER_RPS * EDGES_PER_SAMPLE;
   localparam int NUMK_W = $clog2(NUM_K + 1);
   localparam int PROD_W = CLK_W + NUMK_W;
   localparam int NUM_W  = PROD_W + FRAC_W;
   localparam int DEN_W  = STAMP_W + CPR_W;
   localparam int CNT_W  = (EDGES_PER_SAMPLE > 1) ? $clog2(EDGES_PER_SAMPLE) : 1;
   localparam int P1_W   = SLOPE_W + TGT_W;
   localparam int DIFF_W = SPEED_W + 1;
   localparam int P2_W   = GAIN_W + 1 + DIFF_W;
   localparam int SUM_W  = P2_W + 2;
   localparam logic signed [SUM_W-1:0] DUTY_CEIL = SUM_W'(DUTY_MAX) <<< SUM_FRAC_W;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_DIV, S_MUL, S_SUM, S_CLAMP, S_RESP
   } state_type;

   // configuration
   logic [CLK_W-1:0]           clock_hz_ff;
   logic [CPR_W-1:0]           cpr_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic [SLOPE_W-1:0]         slope_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic [TGT_W-1:0]           max_target_ff;

   // controller state
   state_type              state_ff;
   logic [CNT_W-1:0]       edge_cnt_ff;
   logic [STAMP_W-1:0]     last_stamp_ff;
   logic [SPEED_W-1:0]     speed_ff;
   logic [TGT_W-1:0]       target_ff;
   logic                   enable_ff;
   logic [DUTY_W-1:0]      duty_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic [P1_W-1:0]        p1_ff;
   logic signed [P2_W-1:0] p2_ff;
   logic signed [SUM_W-1:0] sum_ff;

   logic                   rsp_valid_ff;
   logic [DUTY_W-1:0]      rsp_duty_ff;
   logic                   rsp_enabled_ff;
   logic [SPEED_W-1:0]     rsp_speed_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic                   req_take;
   logic                   out_free;
   logic                   sample;
   logic                   fifo_push;
   logic                   fifo_pop;
   logic [STAMP_W-1:0]     period;
   logic [STAMP_W-1:0]     pop_period;
   fifo_status_type        fifo_status;
   logic [STATUS_W-1:0]    target_status;

   logic                   div_start;
   logic                   div_done;
   logic [PROD_W-1:0]      num_prod;
   logic [NUM_W-1:0]       div_num;
   logic [DEN_W-1:0]       div_den;
   logic [SPEED_W-1:0]     div_quo;

   logic [P1_W-1:0]         p1_in;
   logic signed [DIFF_W-1:0] diff;
   logic signed [P2_W-1:0]  p2_in;
   logic signed [SUM_W-1:0] sum_in;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff   <= CLOCK_HZ_RST;
         cpr_ff        <= CPR_RST;
         gain_ff       <= GAIN_RST;
         slope_ff      <= SLOPE_RST;
         offset_ff     <= OFFSET_RST;
         max_target_ff <= MAX_TARGET_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CLOCK_HZ:   clock_hz_ff   <= csr_wdata[CLK_W-1:0];
            REG_CPR:        cpr_ff        <= csr_wdata[CPR_W-1:0];
            REG_GAIN:       gain_ff       <= csr_wdata[GAIN_W-1:0];
            REG_SLOPE:      slope_ff      <= csr_wdata[SLOPE_W-1:0];
            REG_OFFSET:     offset_ff     <= $signed(csr_wdata[OFFSET_W-1:0]);
            REG_MAX_TARGET: max_target_ff <= csr_wdata[TGT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- period queue ----
   assign sample    = req_take && (req_cmd == CMD_EDGE)
                      && (edge_cnt_ff == CNT_W'(EDGES_PER_SAMPLE - 1));
   assign period    = req_stamp - last_stamp_ff;
   assign fifo_push = sample;
   assign fifo_pop  = req_take && (req_cmd == CMD_TICK) && !fifo_status.empty;

   esc_fifo #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (STAMP_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (period),
      .pop       (fifo_pop),
      .pop_data  (pop_period),
      .status    (fifo_status)
   );

   // ---- speed measurement ----
   assign num_prod  = PROD_W'(clock_hz_ff) * PROD_W'(NUM_K);
   assign div_num   = {num_prod, {FRAC_W{1'b0}}};
   assign div_den   = DEN_W'(pop_period) * DEN_W'(cpr_ff);
   assign div_start = (state_ff == S_LOAD) && (pop_period != '0);

   esc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (SPEED_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // range check comes before the enable check
   always_comb begin
      priority if (req_target_value == '0
                   || req_target_value > TV_W'(max_target_ff)) begin
         target_status = STATUS_RANGE;
      end else if (!enable_ff) begin
         target_status = STATUS_DISABLED;
      end else begin
         target_status = STATUS_OK;
      end
   end

   // ---- duty arithmetic, Q24.16 ----
   always_comb begin
      p1_in  = P1_W'(slope_ff) * P1_W'(target_ff);
      diff   = $signed({1'b0, target_ff, {FRAC_W{1'b0}}}) - $signed({1'b0, speed_ff});
      p2_in  = $signed({1'b0, gain_ff}) * diff;
      sum_in = $signed({{(SUM_W-P1_W-FRAC_W){1'b0}}, p1_ff, {FRAC_W{1'b0}}})
             + $signed({{(SUM_W-OFFSET_W-FRAC_W){offset_ff[OFFSET_W-1]}},
                        offset_ff, {FRAC_W{1'b0}}})
             + $signed({{(SUM_W-P2_W){p2_ff[P2_W-1]}}, p2_ff});
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edge_cnt_ff   <= '0;
         last_stamp_ff <= '0;
         speed_ff      <= '0;
         target_ff     <= TARGET_RST;
         enable_ff     <= 1'b1;
         duty_ff       <= '0;
         status_ff     <= STATUS_OK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // in S_RESP a free output register is reloaded below
         if (!rsp_stall && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  status_ff <= (req_cmd == CMD_TARGET) ? target_status : STATUS_OK;
                  if (req_cmd == CMD_TICK) begin
                     state_ff <= fifo_status.empty ? S_MUL : S_LOAD;
                  end else begin
                     state_ff <= S_RESP;
                  end
                  unique case (req_cmd)
                     CMD_EDGE: begin
                        if (sample) begin
                           edge_cnt_ff   <= '0;
                           last_stamp_ff <= req_stamp;
                        end else begin
                           edge_cnt_ff <= edge_cnt_ff + 1'b1;
                        end
                     end
                     CMD_TARGET: begin
                        if (target_status == STATUS_OK) begin
                           target_ff <= req_target_value[TGT_W-1:0];
                        end
                     end
                     CMD_ESTOP: begin
                        enable_ff <= 1'b0;
                        duty_ff   <= '0;
                     end
                     CMD_ENABLE: begin
                        enable_ff <= 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            S_LOAD: begin
               // zero period is consumed without a measurement
               state_ff <= (pop_period != '0) ? S_DIV : S_MUL;
            end
            S_DIV: begin
               if (div_done) begin
                  speed_ff <= div_quo;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               p1_ff    <= p1_in;
               p2_ff    <= p2_in;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               sum_ff   <= sum_in;
               state_ff <= S_CLAMP;
            end
            S_CLAMP: begin
               if (!enable_ff || sum_ff[SUM_W-1]) begin
                  duty_ff <= '0;
               end else if (sum_ff > DUTY_CEIL) begin
                  duty_ff <= DUTY_MAX;
               end else begin
                  duty_ff <= sum_ff[SUM_FRAC_W +: DUTY_W];
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_duty_ff    <= duty_ff;
                  rsp_enabled_ff <= enable_ff;
                  rsp_speed_ff   <= speed_ff;
                  rsp_status_ff  <= status_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_duty     = rsp_duty_ff;
   assign rsp_enabled  = rsp_enabled_ff;
   assign rsp_speed_q8 = rsp_speed_ff;
   assign rsp_status   = rsp_status_ff;

   // ---- assertions ----
   a_disabled_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_enabled |-> rsp_duty == '0)
      else $error("nonzero duty while drive disabled");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= DUTY_MAX)
      else $error("duty above 100 percent");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside of a measurement");

   a_edge_cnt_range: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= CNT_W'(EDGES_PER_SAMPLE - 1))
      else $error("edge counter past sample point");

endmodule

`default_nettype wire
